@@ rtl/pnpp_pkg.sv @@
// ----------------------------------------------------------------------------
// pnpp_pkg
// Shared types and constants of the polyline nearest point projection unit.
// ----------------------------------------------------------------------------
package pnpp_pkg;

    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int RATIO_W    = 17;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_CNT_W  = 5;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRAC_BITS);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_LEN1,
        S_LEN2,
        S_DOT1,
        S_DOT2,
        S_DOT3,
        S_DECIDE,
        S_DIV,
        S_ROUND,
        S_SC1,
        S_SC2,
        S_DIST1,
        S_DIST2,
        S_CMP,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

@@ rtl/pnpp_if.sv @@
// ----------------------------------------------------------------------------
// pnpp_if
// Handshake channels: request, result and configuration write.
// ----------------------------------------------------------------------------
interface pnpp_req_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [9:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic [9:0]                   range_start;
    logic [9:0]                   range_end;
    modport source (output valid, req_type, vertex_index, coord_x, coord_y,
                    range_start, range_end, input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y,
                    range_start, range_end, output ready);
endinterface

interface pnpp_res_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [9:0]                   seg_idx;
    logic [16:0]                  ratio;
    logic signed [COORD_BITS-1:0] proj_x;
    logic signed [COORD_BITS-1:0] proj_y;
    modport source (output valid, found, seg_idx, ratio, proj_x, proj_y,
                    input ready);
    modport sink   (input valid, found, seg_idx, ratio, proj_x, proj_y,
                    output ready);
endinterface

interface pnpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/polyline_nearest_point_projection_unit.sv @@
// ----------------------------------------------------------------------------
// polyline_nearest_point_projection_unit
// Vertex table plus a sequencer that walks the segments of a query range on
// one shared multiplier and a one-bit-per-cycle restoring divider.
//
//   channel  dir  payload
//   i_req    in   req_type, vertex_index, coord_x, coord_y, range_*
//   o_res    out  found, seg_idx, ratio, proj_x, proj_y
//   i_cfg    in   vertex_count
//
// a query walks each segment of its range in turn: read both vertices, form
// the squared length and dot product, then, for a nonzero length, divide
// (16 steps) and round or clamp the ratio, scale, form the distance, compare;
// the memory read port and the shared multiplier serialise these steps.
// i_req.ready is low while a query runs; i_cfg is always ready.
// reset is synchronous, active low; the vertex table is not cleared.
// ----------------------------------------------------------------------------
module polyline_nearest_point_projection_unit
    import pnpp_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pnpp_req_if.sink   i_req,
    pnpp_res_if.source o_res,
    pnpp_cfg_if.sink   i_cfg
);

    localparam int CB = COORD_BITS;
    localparam int MW = CB + 2;
    localparam int PW = 2 * MW;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_count;
    logic signed [CB-1:0]   r_px, r_py, r_sx, r_sy, r_qx, r_qy;
    logic [IDX_W-1:0]       r_idx, r_last;
    logic signed [MW-1:0]   r_dx, r_dy, r_ax, r_ay;
    logic signed [PW-1:0]   r_len2, r_dot;
    logic [PW-1:0]          r_rem, r_dist;
    logic [RATIO_W-1:0]     r_q;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_found;
    logic [PW-1:0]          r_best_d;
    logic [IDX_W-1:0]       r_best_idx;
    logic [RATIO_W-1:0]     r_best_ratio;
    logic signed [CB-1:0]   r_best_x, r_best_y;
    logic                   r_out_valid;

    logic                   req_acc, out_free;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic [AW-1:0]          raddr;
    logic [2*CB-1:0]        rdata;
    logic                   mem_we;

    // query setup
    logic [CNT_W-1:0]       n_eff, nm1, nm2;
    logic [IDX_W-1:0]       first, lastp;
    logic                   range_ok;

    // datapath helpers
    logic signed [CB-1:0]   rd_x, rd_y;
    logic [PW-1:0]          rem2;
    logic signed [PW-1:0]   scaled;
    logic signed [PW-1:0]   q_sum;
    logic [PW-1:0]          dist_sum;
    logic                   last_seg;

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign mem_we = req_acc && (i_req.req_type == REQ_LOAD) &&
                    ({22'd0, i_req.vertex_index} < 32'(MAX_VERTICES));

    always_comb begin
        if ({21'd0, r_count} > 32'(MAX_VERTICES)) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = r_count;
        end
        nm1 = n_eff - CNT_W'(1);
        nm2 = n_eff - CNT_W'(2);
        first = ({1'b0, i_req.range_start} > nm2) ? nm2[IDX_W-1:0] : i_req.range_start;
        lastp = ({1'b0, i_req.range_end} > nm1) ? nm1[IDX_W-1:0] : i_req.range_end;
        range_ok = (n_eff >= CNT_W'(2)) && (lastp != '0) && (first < lastp);
    end

    assign rd_x = rdata[2*CB-1:CB];
    assign rd_y = rdata[CB-1:0];
    assign rem2 = {r_rem[PW-2:0], 1'b0};
    assign scaled = (prod + PW'(32768)) >>> FRAC_BITS;
    assign dist_sum = r_dist + PW'(prod);
    assign last_seg = (r_idx + IDX_W'(1)) >= r_last;

    always_comb begin
        q_sum = '0;
        if (r_state == S_SC2) begin
            q_sum = PW'(r_sx) + scaled;
        end else if (r_state == S_DIST1) begin
            q_sum = PW'(r_sy) + scaled;
        end
    end

    pnpp_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (2 * CB)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_req.vertex_index)),
        .i_wdata ({i_req.coord_x, i_req.coord_y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pnpp_mul_unit #(
        .MW (MW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && (i_req.req_type == REQ_QUERY)) begin
                    n_state = range_ok ? S_RD0 : S_DONE;
                end
            end
            S_RD0:    n_state = S_RD1;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_LEN1;
            S_LEN1:   n_state = S_LEN2;
            S_LEN2:   n_state = S_DOT1;
            S_DOT1:   n_state = S_DOT2;
            S_DOT2:   n_state = S_DOT3;
            S_DOT3:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_len2 == '0) begin
                    n_state = S_NEXT;
                end else if (r_dot[PW-1] || r_dot == '0 || r_dot >= r_len2) begin
                    n_state = S_SC1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:    n_state = (r_cnt == DIV_CNT_W'(FRAC_BITS - 1)) ? S_ROUND : S_DIV;
            S_ROUND:  n_state = S_SC1;
            S_SC1:    n_state = S_SC2;
            S_SC2:    n_state = S_DIST1;
            S_DIST1:  n_state = S_DIST2;
            S_DIST2:  n_state = S_CMP;
            S_CMP:    n_state = S_NEXT;
            S_NEXT:   n_state = last_seg ? S_DONE : S_RD0;
            S_DONE:   n_state = out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // multiplier operands and read address
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        raddr = AW'(r_idx);
        unique case (r_state)
            S_RD1:   raddr = AW'(r_idx + IDX_W'(1));
            S_LEN1:  begin mul_a = r_dx; mul_b = r_dx; end
            S_LEN2:  begin mul_a = r_dy; mul_b = r_dy; end
            S_DOT1:  begin mul_a = r_ax; mul_b = r_dx; end
            S_DOT2:  begin mul_a = r_ay; mul_b = r_dy; end
            S_SC1:   begin mul_a = r_dx; mul_b = MW'($signed({1'b0, r_q})); end
            S_SC2:   begin mul_a = r_dy; mul_b = MW'($signed({1'b0, r_q})); end
            S_DIST1: begin
                mul_a = MW'(r_qx) - MW'(r_px);
                mul_b = MW'(r_qx) - MW'(r_px);
            end
            S_DIST2: begin
                mul_a = MW'(r_qy) - MW'(r_py);
                mul_b = MW'(r_qy) - MW'(r_py);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_count <= i_cfg.data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && req_acc) begin
                r_found <= 1'b0;
            end
            if (r_state == S_CMP && (!r_found || dist_sum < r_best_d)) begin
                r_found <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_px   <= i_req.coord_x;
                r_py   <= i_req.coord_y;
                r_idx  <= first;
                r_last <= lastp;
            end
            S_RD1: begin
                r_sx <= rd_x;
                r_sy <= rd_y;
            end
            S_RD2: begin
                r_dx <= MW'(rd_x) - MW'(r_sx);
                r_dy <= MW'(rd_y) - MW'(r_sy);
                r_ax <= MW'(r_px) - MW'(r_sx);
                r_ay <= MW'(r_py) - MW'(r_sy);
            end
            S_LEN2: r_len2 <= prod;
            S_DOT1: r_len2 <= r_len2 + prod;
            S_DOT2: r_dot  <= prod;
            S_DOT3: r_dot  <= r_dot + prod;
            S_DECIDE: begin
                r_rem <= PW'(r_dot);
                r_cnt <= '0;
                if (r_dot[PW-1] || r_dot == '0) begin
                    r_q <= '0;
                end else if (r_dot >= r_len2) begin
                    r_q <= RATIO_ONE;
                end else begin
                    r_q <= '0;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (rem2 >= PW'(r_len2)) begin
                    r_rem <= rem2 - PW'(r_len2);
                    r_q   <= {r_q[RATIO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[RATIO_W-2:0], 1'b0};
                end
            end
            S_ROUND: begin
                // round half up on the remainder
                if (r_rem >= PW'(r_len2) - r_rem) begin
                    r_q <= r_q + RATIO_W'(1);
                end
            end
            S_SC2:   r_qx   <= CB'(q_sum);
            S_DIST1: r_qy   <= CB'(q_sum);
            S_DIST2: r_dist <= PW'(prod);
            S_CMP: begin
                if (!r_found || dist_sum < r_best_d) begin
                    r_best_d     <= dist_sum;
                    r_best_idx   <= r_idx;
                    r_best_ratio <= r_q;
                    r_best_x     <= r_qx;
                    r_best_y     <= r_qy;
                end
            end
            S_NEXT: r_idx <= r_idx + IDX_W'(1);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_res.found   <= r_found;
            o_res.seg_idx <= r_found ? r_best_idx : '0;
            o_res.ratio   <= r_found ? r_best_ratio : '0;
            o_res.proj_x  <= r_found ? r_best_x : '0;
            o_res.proj_y  <= r_found ? r_best_y : '0;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

@@ rtl/pnpp_vertex_mem.sv @@
// ----------------------------------------------------------------------------
// pnpp_vertex_mem
// Vertex store: one write port, one registered read port, x and y together.
// ----------------------------------------------------------------------------
module pnpp_vertex_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pnpp_mul_unit.sv @@
// ----------------------------------------------------------------------------
// pnpp_mul_unit
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pnpp_mul_unit #(
    parameter int MW = 26
) (
    input  logic                   i_clk,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_prod
);

    logic signed [2*MW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ tb/polyline_nearest_point_projection_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_nearest_point_projection_unit_tb
// Loads vertex tables under several vertex counts and fires projection queries
// at them; results are compared with a behavioral projection or a table entry.
// ----------------------------------------------------------------------------
module polyline_nearest_point_projection_unit_tb;
    import pnpp_pkg::*;

    typedef struct {
        logic               found;
        logic [9:0]         seg;
        logic [16:0]        ratio;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } proj_t;

    typedef struct {
        logic               kind;
        logic [9:0]         vidx;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [9:0]         rs;
        logic [9:0]         re;
    } item_t;

    typedef struct {
        bit        is_cfg;
        int        cfg_val;
        item_t     it;
        bit        typed;
        proj_t     exp_res;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pnpp_req_if #(.COORD_BITS(24)) req_ch();
    pnpp_res_if #(.COORD_BITS(24)) res_ch();
    pnpp_cfg_if                    cfg_ch();

    polyline_nearest_point_projection_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the vertex table and count register
    logic signed [23:0] shadow_x [1024];
    logic signed [23:0] shadow_y [1024];
    bit                 written [1024];
    int                 shadow_count;
    proj_t              pending_proj[$];
    int                 errors;
    bit                 no_idle;
    int                 stall_left = 0;
    row_t               dir_rows[$];

    function automatic proj_t project_point(item_t q);
        proj_t   r;
        longint  n, first, lastp, sx, sy, dx, dy, len2, dot, qx, qy, ex, ey;
        longint  rem, rt;
        longint unsigned d2, best_d;
        r = '{1'b0, 10'd0, 17'd0, 24'sd0, 24'sd0};
        best_d = 0;
        n = (shadow_count > 1024) ? 1024 : shadow_count;
        if (n < 2) return r;
        first = (q.rs > n - 2) ? n - 2 : q.rs;
        lastp = (q.re > n - 1) ? n - 1 : q.re;
        if (lastp == 0 || first >= lastp) return r;
        for (longint i = first; i < lastp; i++) begin
            sx = shadow_x[i];
            sy = shadow_y[i];
            dx = longint'(shadow_x[i+1]) - sx;
            dy = longint'(shadow_y[i+1]) - sy;
            len2 = dx * dx + dy * dy;
            dot = (longint'(q.x) - sx) * dx + (longint'(q.y) - sy) * dy;
            if (len2 == 0) continue;
            if (dot <= 0) rt = 0;
            else if (dot >= len2) rt = 65536;
            else begin
                rem = dot;
                rt = 0;
                for (int b = 0; b < FRAC_BITS; b++) begin
                    rem = rem <<< 1;
                    rt = rt <<< 1;
                    if (rem >= len2) begin
                        rem -= len2;
                        rt |= 1;
                    end
                end
                if (rem >= len2 - rem) rt += 1;
            end
            // arithmetic shift gives the floor that half-up rounding needs
            qx = sx + ((dx * rt + 32768) >>> 16);
            qy = sy + ((dy * rt + 32768) >>> 16);
            ex = qx - q.x;
            ey = qy - q.y;
            d2 = longint'(ex * ex) + longint'(ey * ey);
            if (!r.found || d2 < best_d) begin
                r.found = 1'b1;
                best_d  = d2;
                r.seg   = i[9:0];
                r.ratio = rt[16:0];
                r.px    = qx[23:0];
                r.py    = qy[23:0];
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        proj_t e;
        if (res_ch.valid && res_ch.ready) begin
            if (pending_proj.size() == 0) begin
                $display("%0t: unexpected result found=%0d seg=%0d", $realtime,
                         res_ch.found, res_ch.seg_idx);
                errors++;
            end else begin
                e = pending_proj.pop_front();
                if (res_ch.found !== e.found) begin
                    $display("%0t: found exp %0d got %0d", $realtime, e.found,
                             res_ch.found);
                    errors++;
                end
                if (res_ch.seg_idx !== e.seg) begin
                    $display("%0t: seg_idx exp %0d got %0d", $realtime, e.seg,
                             res_ch.seg_idx);
                    errors++;
                end
                if (res_ch.ratio !== e.ratio) begin
                    $display("%0t: ratio exp %0d got %0d", $realtime, e.ratio,
                             res_ch.ratio);
                    errors++;
                end
                if (res_ch.proj_x !== e.px) begin
                    $display("%0t: proj_x exp %0d got %0d", $realtime, e.px,
                             res_ch.proj_x);
                    errors++;
                end
                if (res_ch.proj_y !== e.py) begin
                    $display("%0t: proj_y exp %0d got %0d", $realtime, e.py,
                             res_ch.proj_y);
                    errors++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            stall_left   <= pick_gap();
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(item_t it, bit typed, proj_t typed_res);
        int    gap;
        proj_t e;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= it.kind;
        req_ch.vertex_index <= it.vidx;
        req_ch.coord_x      <= it.x;
        req_ch.coord_y      <= it.y;
        req_ch.range_start  <= it.rs;
        req_ch.range_end    <= it.re;
        do @(posedge i_clk); while (!req_ch.ready);
        if (it.kind == REQ_LOAD) begin
            shadow_x[it.vidx] = it.x;
            shadow_y[it.vidx] = it.y;
            written[it.vidx]  = 1'b1;
        end else begin
            e = typed ? typed_res : project_point(it);
            pending_proj.insert(pending_proj.size(), e);
        end
    endtask

    task automatic add_row(row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_proj.size() != 0) @(posedge i_clk);
        // a trailing load may still be in flight
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_count(int val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val[10:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_count = val;
    endtask

    function automatic logic signed [23:0] pick_coord(logic signed [23:0] near);
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'(near + $signed($urandom_range(0, 40)) - 20);
            2: return 24'($urandom_range(0, 3));
            default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic item_t load_item(int idx);
        item_t it;
        it.kind = REQ_LOAD;
        it.vidx = idx[9:0];
        it.x    = pick_coord(idx > 0 ? shadow_x[idx-1] : 24'sd0);
        it.y    = pick_coord(idx > 0 ? shadow_y[idx-1] : 24'sd0);
        it.rs   = 10'($urandom);
        it.re   = 10'($urandom);
        return it;
    endfunction

    function automatic row_t mk_row(bit is_cfg, int cv, logic kind, int vi, int x, int y,
                                    int rs, int re, bit typed, proj_t e);
        row_t r;
        r.is_cfg  = is_cfg;
        r.cfg_val = cv;
        r.it      = '{kind, vi[9:0], x[23:0], y[23:0], rs[9:0], re[9:0]};
        r.typed   = typed;
        r.exp_res = e;
        return r;
    endfunction

    initial begin
        #40_000_000;
        $display("polyline_nearest_point_projection_unit verification failed");
        $finish;
    end

    initial begin
        proj_t nil, half, at_start, at_end;
        item_t it;
        int    phase_counts[8];
        int    long_left, n, top, lim, span;
        nil      = '{1'b0, 10'd0, 17'd0, 24'sd0, 24'sd0};
        half     = '{1'b1, 10'd0, 17'd32768, 24'sd50, 24'sd0};
        at_start = '{1'b1, 10'd0, 17'd0, 24'sd0, 24'sd0};
        at_end   = '{1'b1, 10'd0, 17'd65536, 24'sd100, 24'sd0};
        errors = 0;
        no_idle = 1'b0;
        shadow_count = 0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.vertex_index <= '0;
        req_ch.coord_x      <= '0;
        req_ch.coord_y      <= '0;
        req_ch.range_start  <= '0;
        req_ch.range_end    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(mk_row(0, 0, REQ_QUERY, 0, 0, 0, 0, 1023, 1, nil));
        add_row(mk_row(1, 1, REQ_LOAD, 0, 0, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 0, 0, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, 5, 5, 0, 1023, 1, nil));
        add_row(mk_row(1, 6, REQ_LOAD, 0, 0, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 1, 100, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 2, 100, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 3, -8388608, 8388607, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 4, 8388607, -8388608, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 5, 0, 0, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, 50, 7, 0, 1, 1, half));
        add_row(mk_row(0, 0, REQ_QUERY, 0, -5, 3, 0, 0, 1, nil));
        // zero-length segment alone in range
        add_row(mk_row(0, 0, REQ_QUERY, 0, 0, 0, 1, 2, 1, nil));
        // start clamps past the end
        add_row(mk_row(0, 0, REQ_QUERY, 0, 3, 3, 5, 1, 1, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, -8388608, -8388608, 1023, 1023,
                       0, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, 8388607, 8388607, 0, 1023, 0, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, -50, 0, 0, 1, 1, at_start));
        add_row(mk_row(0, 0, REQ_QUERY, 0, 500, 0, 0, 1, 1, at_end));
        add_row(mk_row(0, 0, REQ_QUERY, 0, 100, 50, 0, 3, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 1023, -1, -1, 1023, 1023, 0, nil));
        add_row(mk_row(0, 0, REQ_LOAD, 682, 5592405, -5592406, 0, 0, 0, nil));
        add_row(mk_row(0, 0, REQ_QUERY, 0, -1, -1, 2, 4, 0, nil));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_count(dir_rows[i].cfg_val);
            else send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp_res);
        end

        // random phases over several counts, extremes included
        phase_counts = '{2, 37, 1, 300, 2047, 1024, 0, 130};
        long_left = 4;
        foreach (phase_counts[p]) begin
            write_count(phase_counts[p]);
            n = (shadow_count > 1024) ? 1024 : shadow_count;
            // queries stay inside the filled part of the table
            lim = (n > 128) ? 128 : n;
            no_idle = (p % 3 == 2);
            // fill every entry a query could read
            for (int v = 0; v < lim; v++)
                if (!written[v] || $urandom_range(0, 3) == 0)
                    send_item(load_item(v), 0, nil);
            for (int k = 0; k < 40; k++) begin
                if (k == 35 && p == 3) drain();
                if ($urandom_range(0, 3) == 0) begin
                    top = (n > 0 && $urandom_range(0, 4) != 0) ? lim - 1 : 1023;
                    send_item(load_item($urandom_range(0, top)), 0, nil);
                end else begin
                    it = load_item(0);
                    it.kind = REQ_QUERY;
                    it.x = pick_coord(lim > 0 ? shadow_x[lim-1] : 24'sd0);
                    it.y = pick_coord(lim > 0 ? shadow_y[lim-1] : 24'sd0);
                    if (long_left > 0 && n > 100 && $urandom_range(0, 30) == 0) begin
                        long_left--;
                        it.rs = 10'd0;
                        it.re = 10'(lim - 1);
                    end else if ($urandom_range(0, 9) == 0) begin
                        it.rs = 10'($urandom);
                        it.re = 10'($urandom_range(0, 1023));
                        if (it.re > it.rs + 20 && n > 40) it.re = it.rs + 10'd20;
                    end else begin
                        it.rs = 10'($urandom_range(0, (lim > 1) ? lim - 1 : 1));
                        span  = $urandom_range(0, 12);
                        it.re = (it.rs + span > 1023) ? 10'd1023 : 10'(it.rs + span);
                    end
                    if (n > lim && it.re >= lim) it.re = 10'(lim - 1);
                    send_item(it, 0, nil);
                end
            end
        end
        req_ch.valid <= 1'b0;
        while (pending_proj.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("polyline_nearest_point_projection_unit verification clean");
        else
            $display("polyline_nearest_point_projection_unit verification failed");
        $finish;
    end

endmodule
